[src/wls_pkg.sv]
`default_nettype none
package wls_pkg;

	localparam int CIRC_W   = 16;
	localparam int RATE_W   = 20;
	localparam int TICK_W   = 20;
	localparam int LAP_W    = 16;
	localparam int SPEED_W  = 16;
	localparam int DIST_W   = 32;
	localparam int PROD_W   = CIRC_W + RATE_W;
	localparam int NUM_W    = PROD_W + 6;
	localparam int DEN_W    = TICK_W + 7;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);
	localparam int CFG_IDX_W = 2;

	localparam logic [CIRC_W-1:0] CIRC_RESET    = CIRC_W'(1257);
	localparam logic [RATE_W-1:0] RATE_RESET    = RATE_W'(62500);
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(624999);

	localparam logic [LAP_W-1:0]   LAP_MAX   = '1;
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CIRC    = 2'd0,
		CFG_RATE    = 2'd1,
		CFG_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_RES
	} state_t;

	typedef struct packed {
		logic               done;
		logic [SPEED_W-1:0] quot_sat;
	} div_stat_t;

endpackage
`default_nettype wire

[src/wls_div.sv]
`default_nettype none
module wls_div import wls_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output div_stat_t             stat
);

	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DEN_W-1:0]     rem_q;
	logic [NUM_W-1:0]     quo_q;
	logic [DEN_W:0]       trial;
	logic [DEN_W:0]       diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den};
	assign fits  = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				cnt_q <= DIV_CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign stat.done     = done_q;
	assign stat.quot_sat = (|quo_q[NUM_W-1:SPEED_W]) ? SPEED_MAX : quo_q[SPEED_W-1:0];

endmodule
`default_nettype wire

[src/wheel_lap_speedometer.sv]
// Wheel speedometer. Each request is a timebase tick (cmd 0) or a sensor level
// change (cmd 1); a change to level 0 counts a lap, captures the tick count as
// the period and restarts the timer. Every request gives one result. A tick, a
// level 1 change or a lap that needs no division goes from idle straight to the
// result state; a lap with at least two session laps and a nonzero period
// passes through the multiply, load and divide states first, where the 42-step
// restoring divider forms the speed. A stalled output holds the next result and
// the input. in_stall is high until the request's result is in the output
// register, and while a register write is pending; cfg_ready is high only while
// idle.
`default_nettype none
module wheel_lap_speedometer import wls_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 cmd,
	input  wire logic                 pin_level,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [LAP_W-1:0]          session_laps,
	output logic [LAP_W-1:0]          total_laps,
	output logic [DIST_W-1:0]         distance_mm,
	output logic [SPEED_W-1:0]        speed_centi_kmh,
	output logic                      timed_out,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	state_t state_q, state_d;

	logic [CIRC_W-1:0]  circ_q;
	logic [RATE_W-1:0]  rate_q;
	logic [TICK_W-1:0]  timeout_q;
	logic [TICK_W-1:0]  tick_q;
	logic [TICK_W-1:0]  period_q;
	logic [LAP_W-1:0]   session_q;
	logic [LAP_W-1:0]   total_q;
	logic               running_q;
	logic [SPEED_W-1:0] speed_q;
	logic               to_q;
	logic               out_valid_q;
	logic [PROD_W-1:0]  prod_q;

	logic              accept;
	logic              lap;
	logic              div_start;
	logic              out_load;
	logic [TICK_W:0]   tick_next;
	logic              tick_over;
	logic [LAP_W-1:0]  sess_inc;
	logic [LAP_W-1:0]  tot_inc;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]  prod_ext;
	logic [DEN_W-1:0]  period_ext;
	div_stat_t         div_stat;

	assign accept    = in_valid && !in_stall;
	assign lap       = cmd && !pin_level;
	assign tick_next = {1'b0, tick_q} + (TICK_W+1)'(1);
	assign tick_over = tick_next > {1'b0, timeout_q};
	assign sess_inc  = (session_q == LAP_MAX) ? session_q : session_q + LAP_W'(1);
	assign tot_inc   = (total_q == LAP_MAX) ? total_q : total_q + LAP_W'(1);

	assign prod_ext   = NUM_W'(prod_q);
	assign period_ext = DEN_W'(period_q);
	assign div_num    = (prod_ext << 5) + (prod_ext << 2);
	assign div_den    = (period_ext << 6) + (period_ext << 5) + (period_ext << 2);

	wls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		cfg_ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = cfg_valid;
				cfg_ready = 1'b1;
				if (in_valid && !cfg_valid) begin
					if (lap && sess_inc > LAP_W'(1) && tick_q != '0) begin
						state_d = ST_MUL;
					end else begin
						state_d = ST_RES;
					end
				end
			end
			ST_MUL: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_d = ST_RES;
				end
			end
			ST_RES: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_q    <= CIRC_RESET;
			rate_q    <= RATE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CIRC:    circ_q    <= cfg_data[CIRC_W-1:0];
				CFG_RATE:    rate_q    <= cfg_data[RATE_W-1:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[TICK_W-1:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q    <= '0;
			period_q  <= '0;
			session_q <= LAP_W'(1);
			total_q   <= '0;
			running_q <= 1'b1;
			speed_q   <= '0;
			to_q      <= 1'b0;
		end else if (accept) begin
			to_q <= 1'b0;
			if (!cmd) begin
				if (running_q) begin
					if (tick_over) begin
						tick_q    <= '0;
						running_q <= 1'b0;
						session_q <= '0;
						to_q      <= 1'b1;
					end else begin
						tick_q <= tick_next[TICK_W-1:0];
					end
				end
			end else if (lap) begin
				session_q <= sess_inc;
				total_q   <= tot_inc;
				period_q  <= tick_q;
				tick_q    <= '0;
				running_q <= 1'b1;
				if (sess_inc <= LAP_W'(1)) begin
					speed_q <= '0;
				end else if (tick_q == '0) begin
					speed_q <= SPEED_MAX;
				end
			end
		end else if (state_q == ST_DIV && div_stat.done) begin
			speed_q <= div_stat.quot_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(circ_q) * PROD_W'(rate_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			session_laps    <= session_q;
			total_laps      <= total_q;
			distance_mm     <= DIST_W'(total_q) * DIST_W'(circ_q);
			speed_centi_kmh <= speed_q;
			timed_out       <= to_q;
		end
	end

	assign out_valid = out_valid_q;

	a_stopped_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> tick_q == '0)
		else $error("tick count nonzero while timer stopped");

	a_timeout_session: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timed_out |-> session_laps == '0)
		else $error("timeout result with nonzero session laps");

	a_first_lap_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && session_laps == LAP_W'(1) |-> speed_centi_kmh == '0)
		else $error("speed nonzero with one session lap");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide state");

	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_MUL || state_q == ST_RES)
		else $error("accepted request did not start work");

endmodule
`default_nettype wire
